// ===== rtl/bmps_pkg.sv =====
// ----------------------------------------------------------------------------
// bmps_pkg : shared types and constants of the masked byte pattern scanner
// Register map, configuration bundle, per-step control and length clamping.
// ----------------------------------------------------------------------------
package bmps_pkg;

   localparam int MAX_PATTERN_DEF = 32;   // default window depth
   localparam int PAT_BYTES       = 32;   // bytes held by the four pattern words
   localparam int LEN_W           = 6;
   localparam int ADDR_W          = 64;
   localparam int COUNT_W         = 32;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_ADDR_W      = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [2:0] {
      IDX_LENGTH = 3'd0,
      IDX_WORD0  = 3'd1,
      IDX_WORD1  = 3'd2,
      IDX_WORD2  = 3'd3,
      IDX_WORD3  = 3'd4,
      IDX_MASK   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]       length;
      logic [8*PAT_BYTES-1:0] pattern;   // byte i at [8*i +: 8]
      logic [PAT_BYTES-1:0]   mask;
   } cfg_type;

   typedef struct packed {
      logic fire;          // one byte is taken in this cycle
      logic range_start;
      logic scan_end;
   } step_type;

   // length 0 acts as 1, lengths beyond the window depth are clamped
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                                input logic [LEN_W-1:0] cap);
      logic [LEN_W-1:0] res;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > cap) begin
         res = cap;
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

// ===== rtl/bmps_if.sv =====
// ----------------------------------------------------------------------------
// bmps_if : stream channels of the masked byte pattern scanner
// Byte channel into the scanner and result channel out of it.
// ----------------------------------------------------------------------------
interface bmps_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [63:0] byte_address;
   logic        range_start;
   logic        scan_end;

   modport source (output valid, data_byte, byte_address, range_start, scan_end,
                   input ready);
   modport sink   (input valid, data_byte, byte_address, range_start, scan_end,
                   output ready);
endinterface

interface bmps_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] match_total;
   logic [63:0] first_match_address;

   modport source (output valid, match_total, first_match_address, input ready);
   modport sink   (input valid, match_total, first_match_address, output ready);
endinterface

// ===== rtl/bmps_csr.sv =====
// ----------------------------------------------------------------------------
// bmps_csr : configuration registers
// APB-style write/read of pattern length, pattern words and compare mask.
// ----------------------------------------------------------------------------
module bmps_csr
   import bmps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [LEN_W-1:0]     length_ff;
   logic [63:0]          word_ff [4];
   logic [PAT_BYTES-1:0] mask_ff;
   logic                 wr_en;
   csr_index_type        idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= LEN_W'(1);
         word_ff[0] <= '0;
         word_ff[1] <= '0;
         word_ff[2] <= '0;
         word_ff[3] <= '0;
         mask_ff    <= '1;
      end else if (wr_en) begin
         unique case (idx)
            IDX_LENGTH: length_ff  <= csr_pwdata[LEN_W-1:0];
            IDX_WORD0:  word_ff[0] <= csr_pwdata;
            IDX_WORD1:  word_ff[1] <= csr_pwdata;
            IDX_WORD2:  word_ff[2] <= csr_pwdata;
            IDX_WORD3:  word_ff[3] <= csr_pwdata;
            IDX_MASK:   mask_ff    <= csr_pwdata[PAT_BYTES-1:0];
            default:    ;   // unmapped, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         IDX_LENGTH: csr_prdata = CSR_DATA_W'(length_ff);
         IDX_WORD0:  csr_prdata = word_ff[0];
         IDX_WORD1:  csr_prdata = word_ff[1];
         IDX_WORD2:  csr_prdata = word_ff[2];
         IDX_WORD3:  csr_prdata = word_ff[3];
         IDX_MASK:   csr_prdata = CSR_DATA_W'(mask_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.length  = length_ff;
   assign cfg.pattern = {word_ff[3], word_ff[2], word_ff[1], word_ff[0]};
   assign cfg.mask    = mask_ff;

endmodule

// ===== rtl/bmps_window.sv =====
// ----------------------------------------------------------------------------
// bmps_window : byte window and masked compare
// Shift register of recent bytes with fill count; flags a match each step.
// ----------------------------------------------------------------------------
module bmps_window
   import bmps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  step_type         step,
   input  logic [7:0]       data_byte,
   input  logic [LEN_W-1:0] len,
   input  cfg_type          cfg,
   output logic             hit
);

   localparam int CAP    = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
   localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int FILL_W = $clog2(CAP + 1);

   logic [7:0]        win_ff [CAP];   // entry 0 is the newest byte
   logic [7:0]        win_in [CAP];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] fill_base;
   logic              all_ok;

   always_comb begin
      win_in[0] = data_byte;
      for (int k = 1; k < CAP; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   always_comb begin
      fill_base = step.range_start ? '0 : fill_ff;
      fill_in   = (fill_base < FILL_W'(CAP)) ? fill_base + FILL_W'(1) : fill_base;
   end

   // pattern byte i lines up with window entry len-1-i
   always_comb begin
      logic [LEN_W:0] pos;
      all_ok = 1'b1;
      for (int i = 0; i < CAP; i++) begin
         pos = {1'b0, len} - (LEN_W+1)'(i) - (LEN_W+1)'(1);
         if (((LEN_W+1)'(i) < {1'b0, len}) && cfg.mask[i] &&
             (win_in[pos[IDX_W-1:0]] != cfg.pattern[8*i +: 8])) begin
            all_ok = 1'b0;
         end
      end
   end

   assign hit = ((LEN_W+1)'(fill_in) >= {1'b0, len}) && all_ok;

   always_ff @(posedge clock) begin
      if (step.fire) begin
         for (int k = 0; k < CAP; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (step.fire) begin
         fill_ff <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAP))
      else $error("window fill beyond depth");

endmodule

// ===== rtl/bmps_tally.sv =====
// ----------------------------------------------------------------------------
// bmps_tally : match counter and first match address
// Saturating count, first start address, cleared after the last byte.
// ----------------------------------------------------------------------------
module bmps_tally
   import bmps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  step_type           step,
   input  logic               hit,
   input  logic [ADDR_W-1:0]  byte_address,
   input  logic [LEN_W-1:0]   len,
   output logic [COUNT_W-1:0] total_now,
   output logic [ADDR_W-1:0]  first_now
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [ADDR_W-1:0]  first_ff;
   logic [ADDR_W-1:0]  first_in;

   always_comb begin
      total_now = count_ff;
      first_now = first_ff;
      if (hit) begin
         if (count_ff == '0) begin
            first_now = byte_address - ADDR_W'(len - LEN_W'(1));
         end
         if (count_ff != COUNT_MAX) begin
            total_now = count_ff + COUNT_W'(1);
         end
      end
      count_in = step.scan_end ? '0 : total_now;
      first_in = step.scan_end ? '0 : first_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
      end else if (step.fire) begin
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (first_ff == '0))
      else $error("first address held without a match");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !step.fire |=> $stable(count_ff) && $stable(first_ff))
      else $error("tally moved without a byte");

endmodule

// ===== rtl/masked_byte_pattern_scanner_top.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top : masked byte pattern scanner
// Counts masked pattern matches over a byte stream, reports per scan.
// ----------------------------------------------------------------------------
// Usage
//   req_ch  : one byte per item with its address, range_start and scan_end.
//   rsp_ch  : one item per scan (after the byte flagged scan_end) carrying the
//             saturating match count and the first match start address.
//   csr_*   : APB-style registers, 64-bit data at byte address 8*i:
//             0 length, 1..4 pattern words, 5 compare mask. Write while idle.
// Timing
//   A byte is taken into the input register; when it fires from there, it is
//   shifted into the window, the masked compare runs over all window bytes in
//   parallel and the tally is updated. The last byte of a scan loads the result
//   register, which holds the item until rsp_ch.ready takes it.
//   Sustained rate is 1 byte per cycle while no scan_end byte waits for a busy
//   result slot, bounded by the window compare and tally update.
// Reset
//   Synchronous, active high: registers to defaults (length 1, pattern 0,
//   mask all ones), window empty, count and first address zero.
// Stall
//   A waiting result sits in the output register; bytes keep flowing. Only a
//   further scan_end byte waits in the input register, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top
   import bmps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   bmps_req_if.sink              req_ch,
   bmps_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

   cfg_type            cfg;
   logic [LEN_W-1:0]   len;

   // input register
   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic               s1_start_ff;
   logic               s1_end_ff;

   // result register
   logic               out_valid_ff;
   logic [COUNT_W-1:0] out_total_ff;
   logic [ADDR_W-1:0]  out_first_ff;

   step_type           step;
   logic               hit;
   logic [COUNT_W-1:0] total_now;
   logic [ADDR_W-1:0]  first_now;
   logic               take_in;

   bmps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign len = eff_len(cfg.length, LEN_W'(CAP));

   // a byte ending a scan needs a free result slot (or one draining now)
   assign step.fire        = s1_valid_ff && (!s1_end_ff || !out_valid_ff || rsp_ch.ready);
   assign step.range_start = s1_start_ff;
   assign step.scan_end    = s1_end_ff;

   assign req_ch.ready = !s1_valid_ff || step.fire;
   assign take_in      = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_byte_ff  <= req_ch.data_byte;
         s1_addr_ff  <= req_ch.byte_address;
         s1_start_ff <= req_ch.range_start;
         s1_end_ff   <= req_ch.scan_end;
      end
   end

   bmps_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (s1_byte_ff),
      .len       (len),
      .cfg       (cfg),
      .hit       (hit)
   );

   bmps_tally u_tally (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .hit          (hit),
      .byte_address (s1_addr_ff),
      .len          (len),
      .total_now    (total_now),
      .first_now    (first_now)
   );

   // result register: loaded by the last byte of a scan
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step.fire && step.scan_end) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire && step.scan_end) begin
         out_total_ff <= total_now;
         out_first_ff <= first_now;
      end
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.match_total         = out_total_ff;
   assign rsp_ch.first_match_address = out_first_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (step.fire && step.scan_end) |=> out_valid_ff)
      else $error("last byte processed without a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |-> !(step.fire && step.scan_end))
      else $error("pending result overwritten");

endmodule
